[rtl/core/escc_pkg.sv]
// Shared types, constants and calendar helpers for the epoch seconds calendar converter.
package escc_pkg;

    localparam logic [31:0] K_YEAR      = 32'd31536000;
    localparam logic [31:0] K_LEAP_YEAR = 32'd31622400;
    localparam logic [31:0] K_DAY       = 32'd86400;
    localparam logic [31:0] K_HOUR      = 32'd3600;
    localparam logic [31:0] K_MINUTE    = 32'd60;
    localparam logic [31:0] K_SECOND    = 32'd1;

    localparam logic [11:0] YEAR_FIRST  = 12'd1970;
    localparam logic [11:0] YEAR_LAST   = 12'd2099;
    localparam logic [11:0] YEAR_SKIP   = 12'd2100;
    localparam logic [11:0] YEAR_END    = 12'd2106;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_FETCH,
        OP_CHECK,
        OP_YADD,
        OP_MADD,
        OP_MAC,
        OP_EMIT_SECS,
        OP_EMIT_ERR,
        OP_YSUB,
        OP_MSUB,
        OP_DIGIT,
        OP_SAVE,
        OP_EMIT_DATE,
        OP_JUMP
    } t_op;

    // Selects the time unit: operand and scale of a multiply-accumulate,
    // base of a digit step, or destination of a save.
    typedef enum logic [1:0] {
        SEL_DAY,
        SEL_HOUR,
        SEL_MINUTE,
        SEL_SECOND
    } t_sel;

    typedef struct packed {
        t_op        op;
        t_sel       sel;
        logic [2:0] shift;
        t_pc        target;
    } t_uword;

    typedef struct packed {
        logic jump;
        logic advance;
    } t_seq_ctl;

    typedef struct packed {
        logic        error;
        logic [31:0] epoch_seconds_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } t_result;

    function automatic logic [31:0] unit_secs(input t_sel s);
        logic [31:0] k;
        unique case (s)
            SEL_DAY:    k = K_DAY;
            SEL_HOUR:   k = K_HOUR;
            SEL_MINUTE: k = K_MINUTE;
            default:    k = K_SECOND;
        endcase
        return k;
    endfunction

    // Valid for years 1970 to 2106, where 2100 is the only multiple of four
    // that is not a leap year.
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_SKIP);
    endfunction

    function automatic logic [31:0] month_secs(input logic [3:0] mon, input logic leap);
        logic [31:0] s;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: s = 32'd2678400;
            4'd4, 4'd6, 4'd9, 4'd11:                    s = 32'd2592000;
            4'd2:    s = leap ? 32'd2505600 : 32'd2419200;
            default: s = 32'd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/escc_in_if.sv]
// Input channel of the converter: handshake and request fields.
interface escc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
    logic [31:0] epoch_seconds_in;

    modport source (
        output valid, cmd, year_in, month_in, day_in, hour_in, minute_in, second_in,
               epoch_seconds_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, year_in, month_in, day_in, hour_in, minute_in, second_in,
               epoch_seconds_in,
        output ready
    );
endinterface

[rtl/core/escc_out_if.sv]
// Output channel of the converter: handshake and result fields.
interface escc_out_if;
    logic        valid;
    logic        ready;
    logic        error;
    logic [31:0] epoch_seconds_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;

    modport source (
        output valid, error, epoch_seconds_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out,
        input  ready
    );
    modport sink (
        input  valid, error, epoch_seconds_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out,
        output ready
    );
endinterface

[rtl/core/escc_seq.sv]
// Microcode sequencer: step counter and control store of the converter.
module escc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  escc_pkg::t_seq_ctl i_ctl,
    output escc_pkg::t_uword  o_uword
);

    localparam escc_pkg::t_pc P_FETCH = 5'd0;
    localparam escc_pkg::t_pc P_ERR   = 5'd9;
    localparam escc_pkg::t_pc P_S2D   = 5'd10;

    escc_pkg::t_pc r_pc;
    escc_pkg::t_pc n_pc;

    function automatic escc_pkg::t_uword mk(
        input escc_pkg::t_op  op,
        input escc_pkg::t_sel sel,
        input logic [2:0]     shift,
        input escc_pkg::t_pc  target
    );
        escc_pkg::t_uword w;
        w.op     = op;
        w.sel    = sel;
        w.shift  = shift;
        w.target = target;
        return w;
    endfunction

    // Addresses 1 to 8 convert a date to seconds, 10 to 30 split seconds
    // into a date. Emit steps return to the fetch step.
    function automatic escc_pkg::t_uword rom_word(input escc_pkg::t_pc pc);
        escc_pkg::t_uword w;
        unique case (pc)
            5'd0:  w = mk(escc_pkg::OP_FETCH,     escc_pkg::SEL_DAY,    3'd0, P_S2D);
            5'd1:  w = mk(escc_pkg::OP_CHECK,     escc_pkg::SEL_DAY,    3'd0, P_ERR);
            5'd2:  w = mk(escc_pkg::OP_YADD,      escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd3:  w = mk(escc_pkg::OP_MADD,      escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd4:  w = mk(escc_pkg::OP_MAC,       escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd5:  w = mk(escc_pkg::OP_MAC,       escc_pkg::SEL_HOUR,   3'd0, P_FETCH);
            5'd6:  w = mk(escc_pkg::OP_MAC,       escc_pkg::SEL_MINUTE, 3'd0, P_FETCH);
            5'd7:  w = mk(escc_pkg::OP_MAC,       escc_pkg::SEL_SECOND, 3'd0, P_FETCH);
            5'd8:  w = mk(escc_pkg::OP_EMIT_SECS, escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd9:  w = mk(escc_pkg::OP_EMIT_ERR,  escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd10: w = mk(escc_pkg::OP_YSUB,      escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd11: w = mk(escc_pkg::OP_MSUB,      escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd12: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_DAY,    3'd4, P_FETCH);
            5'd13: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_DAY,    3'd3, P_FETCH);
            5'd14: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_DAY,    3'd2, P_FETCH);
            5'd15: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_DAY,    3'd1, P_FETCH);
            5'd16: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd17: w = mk(escc_pkg::OP_SAVE,      escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            5'd18: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_HOUR,   3'd4, P_FETCH);
            5'd19: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_HOUR,   3'd3, P_FETCH);
            5'd20: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_HOUR,   3'd2, P_FETCH);
            5'd21: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_HOUR,   3'd1, P_FETCH);
            5'd22: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_HOUR,   3'd0, P_FETCH);
            5'd23: w = mk(escc_pkg::OP_SAVE,      escc_pkg::SEL_HOUR,   3'd0, P_FETCH);
            5'd24: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd5, P_FETCH);
            5'd25: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd4, P_FETCH);
            5'd26: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd3, P_FETCH);
            5'd27: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd2, P_FETCH);
            5'd28: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd1, P_FETCH);
            5'd29: w = mk(escc_pkg::OP_DIGIT,     escc_pkg::SEL_MINUTE, 3'd0, P_FETCH);
            5'd30: w = mk(escc_pkg::OP_EMIT_DATE, escc_pkg::SEL_DAY,    3'd0, P_FETCH);
            default: w = mk(escc_pkg::OP_JUMP,    escc_pkg::SEL_DAY,    3'd0, P_FETCH);
        endcase
        return w;
    endfunction

    always_comb begin
        if (i_ctl.jump) begin
            n_pc = o_uword.target;
        end else if (i_ctl.advance) begin
            n_pc = r_pc + escc_pkg::t_pc'(1);
        end else begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = rom_word(r_pc);

endmodule

[rtl/core/epoch_seconds_calendar_converter_unit.sv]
// Top level of the epoch seconds calendar converter: datapath and result register.
// A conversion runs as long as its year and month loops in the microcode take. One input beat
// is taken per conversion; the next beat is fetched only after the result is in the output
// register.
// Reset (synchronous, active low) returns the sequencer to its fetch step and empties the output.
module epoch_seconds_calendar_converter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    escc_in_if.sink   i_in,
    escc_out_if.source o_out
);

    escc_pkg::t_uword   w_uw;
    escc_pkg::t_seq_ctl w_seq;

    logic [11:0] r_year_in;
    logic [3:0]  r_month_in;
    logic [4:0]  r_day_in;
    logic [4:0]  r_hour_in;
    logic [5:0]  r_minute_in;
    logic [5:0]  r_second_in;
    logic [31:0] r_acc;
    logic [11:0] r_year;
    logic [3:0]  r_mon;
    logic [5:0]  r_q;
    logic [4:0]  r_day_o;
    logic [4:0]  r_hour_o;
    logic        r_out_valid;
    escc_pkg::t_result r_res;

    logic [11:0] n_year_in;
    logic [3:0]  n_month_in;
    logic [4:0]  n_day_in;
    logic [4:0]  n_hour_in;
    logic [5:0]  n_minute_in;
    logic [5:0]  n_second_in;
    logic [31:0] n_acc;
    logic [11:0] n_year;
    logic [3:0]  n_mon;
    logic [5:0]  n_q;
    logic [4:0]  n_day_o;
    logic [4:0]  n_hour_o;
    logic        n_out_valid;
    escc_pkg::t_result n_res;

    logic        w_in_ready;
    logic        w_load_out;
    logic        w_out_free;
    logic        w_err;
    logic [31:0] w_year_len;
    logic [31:0] w_mon_len;
    logic [31:0] w_mac_opnd;
    logic [31:0] w_mac_prod;
    logic [31:0] w_digit_k;

    escc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_seq),
        .o_uword (w_uw)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_err = (r_year_in < escc_pkg::YEAR_FIRST) || (r_year_in > escc_pkg::YEAR_LAST)
                || (r_month_in < escc_pkg::MONTH_FIRST) || (r_month_in > escc_pkg::MONTH_LAST);
    assign w_year_len = escc_pkg::is_leap(r_year) ? escc_pkg::K_LEAP_YEAR : escc_pkg::K_YEAR;
    // In the date to seconds program the year counter already equals the
    // requested year when the month loop runs.
    assign w_mon_len  = escc_pkg::month_secs(r_mon, escc_pkg::is_leap(r_year));
    assign w_digit_k  = escc_pkg::unit_secs(w_uw.sel) << w_uw.shift;

    always_comb begin
        case (w_uw.sel)
            escc_pkg::SEL_DAY:    w_mac_opnd = 32'(r_day_in) - 32'd1;
            escc_pkg::SEL_HOUR:   w_mac_opnd = 32'(r_hour_in);
            escc_pkg::SEL_MINUTE: w_mac_opnd = 32'(r_minute_in);
            default:              w_mac_opnd = 32'(r_second_in);
        endcase
    end

    // Products wrap modulo 2^32, which gives day zero its one-day deficit.
    assign w_mac_prod = w_mac_opnd * escc_pkg::unit_secs(w_uw.sel);

    always_comb begin
        n_year_in   = r_year_in;
        n_month_in  = r_month_in;
        n_day_in    = r_day_in;
        n_hour_in   = r_hour_in;
        n_minute_in = r_minute_in;
        n_second_in = r_second_in;
        n_acc       = r_acc;
        n_year      = r_year;
        n_mon       = r_mon;
        n_q         = r_q;
        n_day_o     = r_day_o;
        n_hour_o    = r_hour_o;
        n_res       = r_res;
        w_seq       = '0;
        w_in_ready  = 1'b0;
        w_load_out  = 1'b0;
        unique case (w_uw.op)
            escc_pkg::OP_FETCH: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_year_in   = i_in.year_in;
                    n_month_in  = i_in.month_in;
                    n_day_in    = i_in.day_in;
                    n_hour_in   = i_in.hour_in;
                    n_minute_in = i_in.minute_in;
                    n_second_in = i_in.second_in;
                    n_acc       = i_in.cmd ? i_in.epoch_seconds_in : 32'd0;
                    n_year      = escc_pkg::YEAR_FIRST;
                    n_mon       = escc_pkg::MONTH_FIRST;
                    n_q         = '0;
                    w_seq.jump    = i_in.cmd;
                    w_seq.advance = !i_in.cmd;
                end
            end
            escc_pkg::OP_CHECK: begin
                w_seq.jump    = w_err;
                w_seq.advance = !w_err;
            end
            escc_pkg::OP_YADD: begin
                if (r_year != r_year_in) begin
                    n_acc  = r_acc + w_year_len;
                    n_year = r_year + 12'd1;
                end else begin
                    w_seq.advance = 1'b1;
                end
            end
            escc_pkg::OP_MADD: begin
                if (r_mon != r_month_in) begin
                    n_acc = r_acc + w_mon_len;
                    n_mon = r_mon + 4'd1;
                end else begin
                    w_seq.advance = 1'b1;
                end
            end
            escc_pkg::OP_MAC: begin
                n_acc = r_acc + w_mac_prod;
                w_seq.advance = 1'b1;
            end
            escc_pkg::OP_EMIT_SECS: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_res = '0;
                    n_res.epoch_seconds_out = r_acc;
                    w_seq.jump = 1'b1;
                end
            end
            escc_pkg::OP_EMIT_ERR: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_res = '0;
                    n_res.error = 1'b1;
                    w_seq.jump = 1'b1;
                end
            end
            escc_pkg::OP_YSUB: begin
                // A leap year with exactly 365 days left stays in that year.
                if (r_acc >= w_year_len) begin
                    n_acc  = r_acc - w_year_len;
                    n_year = r_year + 12'd1;
                end else begin
                    w_seq.advance = 1'b1;
                end
            end
            escc_pkg::OP_MSUB: begin
                if ((r_mon <= escc_pkg::MONTH_LAST) && (r_acc >= w_mon_len)) begin
                    n_acc = r_acc - w_mon_len;
                    n_mon = r_mon + 4'd1;
                end else begin
                    w_seq.advance = 1'b1;
                end
            end
            escc_pkg::OP_DIGIT: begin
                if (r_acc >= w_digit_k) begin
                    n_acc = r_acc - w_digit_k;
                    n_q   = {r_q[4:0], 1'b1};
                end else begin
                    n_q   = {r_q[4:0], 1'b0};
                end
                w_seq.advance = 1'b1;
            end
            escc_pkg::OP_SAVE: begin
                case (w_uw.sel)
                    escc_pkg::SEL_DAY:  n_day_o  = r_q[4:0] + 5'd1;
                    escc_pkg::SEL_HOUR: n_hour_o = r_q[4:0];
                    default:            n_hour_o = r_hour_o;
                endcase
                n_q = '0;
                w_seq.advance = 1'b1;
            end
            escc_pkg::OP_EMIT_DATE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_res = '0;
                    n_res.year_out   = r_year;
                    n_res.month_out  = r_mon;
                    n_res.day_out    = r_day_o;
                    n_res.hour_out   = r_hour_o;
                    n_res.minute_out = r_q;
                    n_res.second_out = r_acc[5:0];
                    w_seq.jump = 1'b1;
                end
            end
            default: begin
                w_seq.jump = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_year      <= escc_pkg::YEAR_FIRST;
            r_mon       <= escc_pkg::MONTH_FIRST;
        end else begin
            r_out_valid <= n_out_valid;
            r_year      <= n_year;
            r_mon       <= n_mon;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year_in   <= n_year_in;
        r_month_in  <= n_month_in;
        r_day_in    <= n_day_in;
        r_hour_in   <= n_hour_in;
        r_minute_in <= n_minute_in;
        r_second_in <= n_second_in;
        r_acc       <= n_acc;
        r_q         <= n_q;
        r_day_o     <= n_day_o;
        r_hour_o    <= n_hour_o;
        r_res       <= n_res;
    end

    assign i_in.ready              = w_in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.error             = r_res.error;
    assign o_out.epoch_seconds_out = r_res.epoch_seconds_out;
    assign o_out.year_out          = r_res.year_out;
    assign o_out.month_out         = r_res.month_out;
    assign o_out.day_out           = r_res.day_out;
    assign o_out.hour_out          = r_res.hour_out;
    assign o_out.minute_out        = r_res.minute_out;
    assign o_out.second_out        = r_res.second_out;

`ifndef SYNTH
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready stayed high after a beat was taken");

    a_year_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_year <= escc_pkg::YEAR_END)
        else $error("year counter ran past the end of the 32-bit range");

    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mon <= escc_pkg::MONTH_LAST + 4'd1)
        else $error("month counter ran past December");

    a_seconds_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == escc_pkg::OP_EMIT_DATE) |-> (r_acc < escc_pkg::K_MINUTE))
        else $error("more than a minute left when the date is emitted");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.error) |-> (r_res.epoch_seconds_out == 32'd0))
        else $error("error result carries a nonzero seconds count");
`endif

endmodule

[tb/epoch_seconds_calendar_converter_unit_test.sv]
// Self-checking testbench for the epoch seconds calendar converter, with its own conversion predictor.
module epoch_seconds_calendar_converter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_TO_SECONDS = 1'b0;
    localparam bit CMD_TO_DATE    = 1'b1;

    localparam int unsigned SECS_PER_YEAR      = 32'd31536000;
    localparam int unsigned SECS_PER_LEAP_YEAR = 32'd31622400;
    localparam int unsigned SECS_PER_DAY       = 32'd86400;
    localparam int unsigned SECS_PER_HOUR      = 32'd3600;
    localparam int unsigned SECS_PER_MINUTE    = 32'd60;
    localparam int unsigned FIRST_YEAR         = 1970;
    localparam int unsigned LAST_YEAR          = 2099;
    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    localparam int RANDOM_REQUESTS = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 400;

    typedef struct {
        bit        cmd;
        bit [11:0] year;
        bit [3:0]  month;
        bit [4:0]  day;
        bit [4:0]  hour;
        bit [5:0]  minute;
        bit [5:0]  second;
        bit [31:0] epoch_seconds;
    } t_calendar_request;

    logic i_clk;
    logic i_rst_n;

    escc_in_if  in_if ();
    escc_out_if out_if ();

    epoch_seconds_calendar_converter_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_calendar_request pending_requests[$];
    escc_pkg::t_result expected_results[$];
    t_calendar_request cur_request;

    int n_requests;
    int n_accepted;
    int n_results;
    int n_to_seconds;
    int n_to_date;
    int n_rejected;
    int n_mismatches;
    int burst_left;
    int gap_left;
    int ready_left;
    bit ready_phase;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = ~i_clk;
    end

    function automatic bit gregorian_leap(input int unsigned y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic escc_pkg::t_result expected_conversion(input t_calendar_request r);
        escc_pkg::t_result res;
        int unsigned total;
        int unsigned days;
        int unsigned rem;
        int unsigned yr;
        int unsigned m;
        int unsigned len;
        res = '0;
        if (r.cmd == CMD_TO_SECONDS) begin
            if (r.year < FIRST_YEAR || r.year > LAST_YEAR || r.month < 1 || r.month > 12) begin
                res.error = 1'b1;
            end else begin
                total = 0;
                for (yr = FIRST_YEAR; yr < r.year; yr++) begin
                    total += gregorian_leap(yr) ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
                end
                for (m = 0; m + 1 < r.month; m++) begin
                    total += DAYS_IN_MONTH[m] * SECS_PER_DAY;
                    if (m == 1 && gregorian_leap(r.year)) total += SECS_PER_DAY;
                end
                // Day zero wraps here, taking one day off modulo 2^32.
                total += (32'(r.day) - 32'd1) * SECS_PER_DAY;
                total += 32'(r.hour) * SECS_PER_HOUR;
                total += 32'(r.minute) * SECS_PER_MINUTE;
                total += 32'(r.second);
                res.epoch_seconds_out = total;
            end
        end else begin
            days = r.epoch_seconds / SECS_PER_DAY;
            rem  = r.epoch_seconds % SECS_PER_DAY;
            yr   = FIRST_YEAR;
            m    = 0;
            while (days >= 365) begin
                if (gregorian_leap(yr)) begin
                    if (days < 366) break;
                    days -= 366;
                end else begin
                    days -= 365;
                end
                yr++;
            end
            while (days >= 28 && m < 12) begin
                len = DAYS_IN_MONTH[m];
                if (m == 1 && gregorian_leap(yr)) len = 29;
                if (days < len) break;
                days -= len;
                m++;
            end
            res.year_out   = 12'(yr);
            res.month_out  = 4'(m + 1);
            res.day_out    = 5'(days + 1);
            res.hour_out   = 5'(rem / SECS_PER_HOUR);
            res.minute_out = 6'((rem % SECS_PER_HOUR) / SECS_PER_MINUTE);
            res.second_out = 6'(rem % SECS_PER_MINUTE);
        end
        return res;
    endfunction

    task automatic push_date(input int y, input int mo, input int d, input int h, input int mi,
                             input int s);
        t_calendar_request r;
        r.cmd           = CMD_TO_SECONDS;
        r.year          = 12'(y);
        r.month         = 4'(mo);
        r.day           = 5'(d);
        r.hour          = 5'(h);
        r.minute        = 6'(mi);
        r.second        = 6'(s);
        r.epoch_seconds = $urandom;
        pending_requests.push_back(r);
    endtask

    task automatic push_seconds(input bit [31:0] secs);
        t_calendar_request r;
        r.cmd           = CMD_TO_DATE;
        r.year          = 12'($urandom);
        r.month         = 4'($urandom);
        r.day           = 5'($urandom);
        r.hour          = 5'($urandom);
        r.minute        = 6'($urandom);
        r.second        = 6'($urandom);
        r.epoch_seconds = secs;
        pending_requests.push_back(r);
    endtask

    task automatic push_random_request();
        int unsigned pick;
        int unsigned y;
        int unsigned mo;
        int unsigned mlen;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // Well-formed date and time.
            y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
            mo   = $urandom_range(1, 12);
            mlen = DAYS_IN_MONTH[mo - 1];
            if (mo == 2 && gregorian_leap(y)) mlen = 29;
            push_date(y, mo, $urandom_range(1, mlen), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 59));
        end else if (pick < 57) begin
            // Any field value, valid or not.
            y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(FIRST_YEAR, LAST_YEAR);
            push_date(y, $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 63), $urandom_range(0, 63));
        end else if (pick < 67) begin
            // Within two seconds of a day boundary, which may also be a month or year boundary.
            push_seconds(32'($urandom_range(0, 4999) * SECS_PER_DAY) + 32'($urandom_range(0, 3))
                         - 32'd2);
        end else begin
            push_seconds($urandom);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      n_results, name, got, want));
        end
    endtask

    // Sender: bursts of back-to-back beats separated by random gaps.
    always @(posedge i_clk) begin
        escc_pkg::t_result pred;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pred = expected_conversion(cur_request);
                expected_results.push_back(pred);
                n_accepted++;
                if (cur_request.cmd == CMD_TO_DATE) n_to_date++;
                else if (pred.error) n_rejected++;
                else n_to_seconds++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_request = pending_requests.pop_front();
                    in_if.valid            <= 1'b1;
                    in_if.cmd              <= cur_request.cmd;
                    in_if.year_in          <= cur_request.year;
                    in_if.month_in         <= cur_request.month;
                    in_if.day_in           <= cur_request.day;
                    in_if.hour_in          <= cur_request.hour;
                    in_if.minute_in        <= cur_request.minute;
                    in_if.second_in        <= cur_request.second;
                    in_if.epoch_seconds_in <= cur_request.epoch_seconds;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternating runs of ready and stalled cycles, checking each result beat.
    always @(posedge i_clk) begin
        escc_pkg::t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            ready_left   = 0;
            ready_phase  = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat arrived with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    compare_field("error", 32'(out_if.error), 32'(want.error));
                    compare_field("epoch_seconds_out", out_if.epoch_seconds_out,
                                  want.epoch_seconds_out);
                    compare_field("year_out", 32'(out_if.year_out), 32'(want.year_out));
                    compare_field("month_out", 32'(out_if.month_out), 32'(want.month_out));
                    compare_field("day_out", 32'(out_if.day_out), 32'(want.day_out));
                    compare_field("hour_out", 32'(out_if.hour_out), 32'(want.hour_out));
                    compare_field("minute_out", 32'(out_if.minute_out), 32'(want.minute_out));
                    compare_field("second_out", 32'(out_if.second_out), 32'(want.second_out));
                end
                n_results++;
            end
            if (ready_left > 0) begin
                ready_left--;
            end else begin
                ready_phase = !ready_phase;
                ready_left  = ready_phase ? $urandom_range(1, 40) : $urandom_range(1, 15);
            end
            out_if.ready <= ready_phase;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        in_if.valid            = 1'b0;
        in_if.cmd              = 1'b0;
        in_if.year_in          = '0;
        in_if.month_in         = '0;
        in_if.day_in           = '0;
        in_if.hour_in          = '0;
        in_if.minute_in        = '0;
        in_if.second_in        = '0;
        in_if.epoch_seconds_in = '0;
        out_if.ready           = 1'b0;
        n_accepted             = 0;
        n_results              = 0;
        n_to_seconds           = 0;
        n_to_date              = 0;
        n_rejected             = 0;
        n_mismatches           = 0;
        idle_cycles            = 0;

        // Calendar extremes, leap days, rejected years and months, and wrapping sums.
        push_date(1970, 1, 1, 0, 0, 0);
        push_date(2099, 12, 31, 23, 59, 59);
        push_date(2000, 2, 29, 12, 34, 56);
        push_date(2000, 3, 1, 0, 0, 0);
        push_date(2096, 2, 29, 23, 59, 59);
        push_date(2100, 1, 1, 0, 0, 0);
        push_date(1969, 12, 31, 23, 59, 59);
        push_date(0, 0, 0, 0, 0, 0);
        push_date(4095, 15, 31, 31, 63, 63);
        push_date(2024, 0, 15, 10, 10, 10);
        push_date(2024, 13, 15, 10, 10, 10);
        push_date(1990, 6, 0, 5, 6, 7);
        push_date(1970, 1, 0, 0, 0, 0);
        push_date(2099, 12, 31, 31, 63, 63);
        push_seconds(32'd0);
        push_seconds(32'hFFFF_FFFF);
        push_seconds(32'd86399);
        push_seconds(32'd951782400);
        push_seconds(32'd951868799);
        push_seconds(32'd4102444799);
        push_seconds(32'd4102444800);
        push_seconds(32'd4107542399);
        push_seconds(32'd4107542400);
        repeat (RANDOM_REQUESTS) push_random_request();
        n_requests = pending_requests.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_requests) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d date to seconds, %0d rejected dates, %0d seconds to date",
                 n_results, n_to_seconds, n_rejected, n_to_date);
        $display("Field mismatches or stray beats: %0d", n_mismatches);
        if (n_mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
